// File: rtl/core/cross_blur_filter_assert.svh
// Assertion shorthands shared by the filter RTL.
// Include guard keeps repeated includes harmless.
`ifndef CROSS_BLUR_FILTER_ASSERT_SVH
`define CROSS_BLUR_FILTER_ASSERT_SVH

// Check a consequence in the same cycle as its cause.
`define XBF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause.
`define XBF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/xbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package xbf_pkg;

    localparam int XBF_MAX_WIDTH   = 1024;
    localparam int XBF_MAX_HEIGHT  = 1024;
    localparam int XBF_CFG_W       = 11;
    localparam int XBF_CFG_RESET   = 1024;
    localparam int XBF_PIX_W       = 8;
    localparam int XBF_POS_W       = 10;
    localparam int XBF_SUM_W       = 11;
    // floor(x / 5) == (x * 3277) >> 14 for every x up to 5 * 255
    localparam int XBF_RECIP       = 3277;
    localparam int XBF_RECIP_SHIFT = 14;
    localparam int XBF_PROD_W      = 23;

    typedef enum logic [0:0] {
        XBF_REG_WIDTH  = 1'b0,
        XBF_REG_HEIGHT = 1'b1
    } t_reg_index;

    typedef struct packed {
        logic single;
        logic has_a;
        logic has_b;
        logic interior;
        logic last_col;
    } t_flags;

    typedef struct packed {
        logic [XBF_PIX_W-1:0] pixel;
        logic [XBF_POS_W-1:0] row;
        logic [XBF_POS_W-1:0] col;
        logic                 frame_end;
    } t_result;

    typedef struct packed {
        logic    any;
        logic    more;
        t_result first;
        t_result second;
    } t_pair;

endpackage

`default_nettype wire

// File: rtl/core/xbf_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface xbf_pix_in_if import xbf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [XBF_PIX_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface xbf_pix_out_if import xbf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [XBF_PIX_W-1:0] pixel_out;
    logic [XBF_POS_W-1:0] out_row;
    logic [XBF_POS_W-1:0] out_col;
    logic                 frame_end;

    modport source (output valid, output pixel_out, output out_row, output out_col,
                    output frame_end, input ready);
    modport sink   (input valid, input pixel_out, input out_row, input out_col,
                    input frame_end, output ready);
endinterface

interface xbf_cfg_if import xbf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [0:0]           reg_index;
    logic [XBF_CFG_W-1:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// File: rtl/core/cross_blur_filter.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Modport  Beat contents                             Direction
// i_pix     sink     pixel_in                                  in
// o_pix     source   pixel_out, out_row, out_col, frame_end    out
// i_cfg     sink     reg_index, wdata (width, height)          in
//
// Cycles: one pixel per clock while o_pix is ready; a last-row pixel yields two
//   results and holds the input back while the output queue drains the pair.
// Pipeline: an input beat passes the line store read, cross sum, reciprocal
//   multiply and output queue registers, in that order, before its first result.
// Reset: synchronous, clears counters and valids and sets both sizes to 1024
//   (clamped to MAX_WIDTH / MAX_HEIGHT); line stores are not cleared.
// Stalls: ready runs back from o_pix through the cell chain to i_pix; each
//   cell keeps its beat until the next one takes it.
module cross_blur_filter
    import xbf_pkg::*;
#(
    parameter int MAX_WIDTH  = XBF_MAX_WIDTH,
    parameter int MAX_HEIGHT = XBF_MAX_HEIGHT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    xbf_pix_in_if.sink    i_pix,
    xbf_pix_out_if.source o_pix,
    xbf_cfg_if.sink       i_cfg
);

`include "cross_blur_filter_assert.svh"

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int W_RST_LAST = ((XBF_CFG_RESET > MAX_WIDTH) ? MAX_WIDTH : XBF_CFG_RESET) - 1;
    localparam int H_RST_LAST = ((XBF_CFG_RESET > MAX_HEIGHT) ? MAX_HEIGHT : XBF_CFG_RESET) - 1;

    // beat held after the line store read
    typedef struct packed {
        logic [XBF_PIX_W-1:0] pix;
        logic [RW-1:0]        row;
        logic [CW-1:0]        col;
        t_flags               flags;
    } t_pos_beat;

    // beat held after the cross sum
    typedef struct packed {
        logic [XBF_SUM_W-1:0] sum;
        logic [XBF_PIX_W-1:0] mid;
        logic [XBF_PIX_W-1:0] pix;
        logic [RW-1:0]        row;
        logic [CW-1:0]        col;
        t_flags               flags;
    } t_sum_beat;

    // beat held after the reciprocal multiply
    typedef struct packed {
        logic [XBF_PROD_W-1:0] prod;
        logic [XBF_PIX_W-1:0]  mid;
        logic [XBF_PIX_W-1:0]  pix;
        logic [RW-1:0]         row;
        logic [CW-1:0]         col;
        t_flags                flags;
    } t_prod_beat;

    // Map a size register to its last index: zero acts as one, large values clamp.
    function automatic int unsigned last_index(input logic [XBF_CFG_W-1:0] v,
                                               input int unsigned maxv);
        int unsigned val;
        val = 32'(v);
        if (val == 0) begin
            return 0;
        end
        if (val > maxv) begin
            return maxv - 1;
        end
        return val - 1;
    endfunction

    // ---------------- configuration ----------------
    logic          cfg_we;
    logic [CW-1:0] r_wlast;
    logic [RW-1:0] r_hlast;

    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlast <= CW'(W_RST_LAST);
            r_hlast <= RW'(H_RST_LAST);
        end else if (cfg_we) begin
            if (i_cfg.reg_index == XBF_REG_WIDTH) begin
                r_wlast <= CW'(last_index(i_cfg.wdata, MAX_WIDTH));
            end else if (i_cfg.reg_index == XBF_REG_HEIGHT) begin
                r_hlast <= RW'(last_index(i_cfg.wdata, MAX_HEIGHT));
            end
        end
    end

    // ---------------- position counters ----------------
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;
    logic [CW-1:0] c_eff;
    logic [RW-1:0] r_eff;
    logic [CW-1:0] right_addr;
    logic          accept;
    t_flags        s0_flags;
    t_pos_beat     s0_beat;

    assign accept = i_pix.valid && i_pix.ready;

    // a counter beyond a shrunken size acts as the last column / row
    assign c_eff      = (r_col > r_wlast) ? r_wlast : r_col;
    assign r_eff      = (r_row > r_hlast) ? r_hlast : r_row;
    assign right_addr = c_eff + CW'(1);

    always_comb begin
        s0_flags.single   = (r_hlast == '0);
        s0_flags.last_col = (c_eff == r_wlast);
        // row r emits row r-1; a one-row frame emits each pixel itself
        s0_flags.has_a    = s0_flags.single || (r_eff != '0);
        // the last row also emits itself
        s0_flags.has_b    = !s0_flags.single && (r_eff == r_hlast);
        // output row r-1 is interior when 1 <= r-1 < hlast
        s0_flags.interior = (c_eff != '0) && (c_eff < r_wlast) && (r_eff >= RW'(2));

        s0_beat.pix   = i_pix.pixel_in;
        s0_beat.row   = r_eff;
        s0_beat.col   = c_eff;
        s0_beat.flags = s0_flags;

        n_col = c_eff + CW'(1);
        n_row = r_eff;
        if (s0_flags.last_col) begin
            n_col = '0;
            n_row = (r_eff == r_hlast) ? '0 : r_eff + RW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---------------- line stores ----------------
    logic [XBF_PIX_W-1:0] mem_older [MAX_WIDTH];
    logic [XBF_PIX_W-1:0] mem_newer [MAX_WIDTH];
    logic [XBF_PIX_W-1:0] r_up2;
    logic [XBF_PIX_W-1:0] r_mid;
    logic [XBF_PIX_W-1:0] r_right;
    logic [XBF_PIX_W-1:0] r_left;

    logic                     s1_valid;
    logic                     s1_ready;
    logic [$bits(t_pos_beat)-1:0] s1_data;
    t_pos_beat                s1_q;
    logic                     s2_ready;
    logic                     s1_fire;

    assign s1_q    = s1_data;
    assign s1_fire = s1_valid && s2_ready;

    // Newer row: read center and right, write the new pixel in its place.
    // Read data registers only on an accepted beat, so they hold through stalls.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mid                <= mem_newer[c_eff];
            r_right              <= mem_newer[right_addr];
            mem_newer[c_eff]     <= i_pix.pixel_in;
        end
    end

    // Older row: read at accept, write back the row-above pixel when the beat moves on.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_up2 <= mem_older[c_eff];
        end
        if (s1_fire) begin
            mem_older[s1_q.col] <= r_mid;
        end
    end

    // left neighbor is the row-above pixel of the previous beat
    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_left <= r_mid;
        end
    end

    // ---------------- cell chain ----------------
    xbf_cell #(.DW($bits(t_pos_beat))) u_cell_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pix.valid),
        .o_ready (s1_ready),
        .i_data  (s0_beat),
        .o_valid (s1_valid),
        .i_ready (s2_ready),
        .o_data  (s1_data)
    );

    assign i_pix.ready = s1_ready;

    t_sum_beat                    s1_sum;
    logic                         s2_valid;
    logic                         s3_ready;
    logic [$bits(t_sum_beat)-1:0] s2_data;
    t_sum_beat                    s2_q;

    always_comb begin
        s1_sum.sum   = XBF_SUM_W'(r_up2) + XBF_SUM_W'(s1_q.pix) + XBF_SUM_W'(r_left)
                     + XBF_SUM_W'(r_right) + XBF_SUM_W'(r_mid);
        s1_sum.mid   = r_mid;
        s1_sum.pix   = s1_q.pix;
        s1_sum.row   = s1_q.row;
        s1_sum.col   = s1_q.col;
        s1_sum.flags = s1_q.flags;
    end

    xbf_cell #(.DW($bits(t_sum_beat))) u_cell_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s2_ready),
        .i_data  (s1_sum),
        .o_valid (s2_valid),
        .i_ready (s3_ready),
        .o_data  (s2_data)
    );

    assign s2_q = s2_data;

    t_prod_beat                    s2_prod;
    logic                          s3_valid;
    logic                          q_ready;
    logic [$bits(t_prod_beat)-1:0] s3_data;
    t_prod_beat                    s3_q;

    // divide by five as a multiply by the scaled reciprocal
    always_comb begin
        s2_prod.prod  = XBF_PROD_W'(s2_q.sum) * XBF_PROD_W'(XBF_RECIP);
        s2_prod.mid   = s2_q.mid;
        s2_prod.pix   = s2_q.pix;
        s2_prod.row   = s2_q.row;
        s2_prod.col   = s2_q.col;
        s2_prod.flags = s2_q.flags;
    end

    xbf_cell #(.DW($bits(t_prod_beat))) u_cell_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s3_ready),
        .i_data  (s2_prod),
        .o_valid (s3_valid),
        .i_ready (q_ready),
        .o_data  (s3_data)
    );

    assign s3_q = s3_data;

    // ---------------- result pair and output queue ----------------
    t_pair                s3_pair;
    logic [XBF_PIX_W-1:0] filt;
    logic [RW-1:0]        row_above;
    t_result              out_res;

    always_comb begin
        filt      = s3_q.flags.interior ? s3_q.prod[XBF_RECIP_SHIFT +: XBF_PIX_W] : s3_q.mid;
        row_above = s3_q.row - RW'(1);

        s3_pair.any  = s3_q.flags.has_a;
        s3_pair.more = s3_q.flags.has_b;

        s3_pair.first.pixel     = s3_q.flags.single ? s3_q.pix : filt;
        s3_pair.first.row       = s3_q.flags.single ? '0 : XBF_POS_W'(row_above);
        s3_pair.first.col       = XBF_POS_W'(s3_q.col);
        s3_pair.first.frame_end = s3_q.flags.single && s3_q.flags.last_col;

        // last row: the pixel itself follows the one above it
        s3_pair.second.pixel     = s3_q.pix;
        s3_pair.second.row       = XBF_POS_W'(s3_q.row);
        s3_pair.second.col       = XBF_POS_W'(s3_q.col);
        s3_pair.second.frame_end = s3_q.flags.last_col;
    end

    xbf_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s3_valid),
        .o_ready  (q_ready),
        .i_pair   (s3_pair),
        .o_valid  (o_pix.valid),
        .i_ready  (o_pix.ready),
        .o_result (out_res)
    );

    assign o_pix.pixel_out = out_res.pixel;
    assign o_pix.out_row   = out_res.row;
    assign o_pix.out_col   = out_res.col;
    assign o_pix.frame_end = out_res.frame_end;

    `XBF_ASSERT_NEXT(a_col_wraps, i_clk, i_rst_n, accept && s0_flags.last_col, r_col == '0, "column counter did not wrap at the last column")
    `XBF_ASSERT_NEXT(a_row_holds, i_clk, i_rst_n, accept && !s0_flags.last_col, r_row == $past(r_eff), "row counter moved inside a row")
    `XBF_ASSERT_NOW(a_stall_blocks_input, i_clk, i_rst_n, s1_valid && !s2_ready, !i_pix.ready, "input taken while the first cell is stalled")

endmodule

`default_nettype wire

// File: rtl/core/xbf_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One elastic pipeline cell: hold a beat, hand it on when the neighbor takes it.
module xbf_cell #(
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [DW-1:0] i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [DW-1:0] o_data
);

    logic          r_valid;
    logic [DW-1:0] r_data;
    logic          n_valid;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/xbf_outq.sv
`timescale 1ns / 1ps
`default_nettype none

`include "cross_blur_filter_assert.svh"

// Two-entry result queue: one beat in may carry two results out.
module xbf_outq
    import xbf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_pair   i_pair,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    logic    r_more;
    t_result r_cur;
    t_result r_nxt;
    logic    n_valid;
    logic    n_more;
    logic    out_fire;
    logic    load;

    assign out_fire = r_valid && i_ready;
    // take a new beat only once the last result of the held one leaves
    assign o_ready  = !r_valid || (out_fire && !r_more);
    // beats without results are consumed and dropped
    assign load     = i_valid && o_ready && i_pair.any;
    assign o_valid  = r_valid;
    assign o_result = r_cur;

    always_comb begin
        n_valid = r_valid;
        n_more  = r_more;
        if (load) begin
            n_valid = 1'b1;
            n_more  = i_pair.more;
        end else if (out_fire) begin
            if (r_more) begin
                n_more = 1'b0;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_more  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_more  <= n_more;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur <= i_pair.first;
            r_nxt <= i_pair.second;
        end else if (out_fire && r_more) begin
            r_cur <= r_nxt;
        end
    end

    `XBF_ASSERT_NOW(a_more_needs_valid, i_clk, i_rst_n, r_more, r_valid, "second result pending without a held beat")
    `XBF_ASSERT_NEXT(a_second_follows, i_clk, i_rst_n, out_fire && r_more, r_valid && !r_more, "second result of a pair not shown next")
    `XBF_ASSERT_NEXT(a_pair_loaded, i_clk, i_rst_n, load && i_pair.more, r_valid && r_more, "pair beat lost its second result")

endmodule

`default_nettype wire
